[hw/rtl/lcp_pkg.sv]
// Shared types, codes and decode helpers of the locomotive card record parser.
package lcp_pkg;

  // Function entries at or above this number are dropped.
  localparam int unsigned FUNCTION_SLOTS = 32;

  localparam logic [7:0] PREAMBLE_LEN = 8'h02;

  // Record indexes with special handling.
  localparam logic [7:0] REC_SECTION0  = 8'd0;
  localparam logic [7:0] REC_UID       = 8'd1;
  localparam logic [7:0] REC_ADDRESS   = 8'd2;
  localparam logic [7:0] REC_TACHO     = 8'd7;
  localparam logic [7:0] REC_VOLUME    = 8'd8;
  localparam logic [7:0] REC_FUNCTION  = 8'd9;
  localparam logic [7:0] REC_MFX_UID   = 8'd10;
  localparam logic [7:0] REC_MFX_TYPE  = 8'd11;
  localparam logic [7:0] REC_MFX_WORD  = 8'd12;
  localparam logic [7:0] REC_FUNC_HI   = 8'd13;
  localparam logic [7:0] REC_SYMBOL_A  = 8'd14;
  localparam logic [7:0] REC_SYMBOL_B  = 8'd15;

  // Section 0 sub-record ids.
  localparam logic [7:0] SUB_NONE  = 8'h00;
  localparam logic [7:0] SUB_PIC   = 8'h05;
  localparam logic [7:0] SUB_NAME  = 8'h1e;
  localparam logic [7:0] SUB_PROTO = 8'h1f;
  localparam logic [7:0] SUB_ICON  = 8'h20;
  localparam logic [7:0] SUB_END   = 8'hff;

  localparam int unsigned FUNC_GROUP_LEN = 10;
  localparam logic [3:0]  GROUP_LAST     = 4'(FUNC_GROUP_LEN - 1);
  localparam logic [7:0]  FUNC_HI_LEN    = 8'd32;
  localparam logic [7:0]  SYMBOL_LEN     = 8'd1;
  localparam logic [5:0]  FUNC_HI_FIRST  = 6'd16;
  localparam logic [5:0]  SLOT_MAX       = 6'd63;
  localparam logic [6:0]  MFX_WORDS      = 7'd8;
  localparam logic [7:0]  STR_SLOTS      = 8'd32;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;
  localparam logic [15:0] CARD_SIZE_RST  = 16'hFFFF;

  localparam int unsigned TYPE_WORD_CNT = 6;
  localparam logic [15:0] TYPE_WORDS [TYPE_WORD_CNT] = '{
    16'h0075, 16'h00C5, 16'h00E5, 16'h00E7, 16'h00F5, 16'h0117
  };
  localparam logic [4:0] TYPE_CODE_UNKNOWN = 5'(TYPE_WORD_CNT);

  typedef enum logic [3:0] {
    PH_LEN, PH_ID0, PH_ID1, PH_IDX, PH_RLEN, PH_DATA, PH_TOT0, PH_TOT1,
    PH_SUB_FIRST, PH_SUB_AFTER, PH_SUB_RETRY, PH_SUB_LEN, PH_STR, PH_PIC_HI,
    PH_DONE
  } lcp_phase_e;

  typedef enum logic [4:0] {
    KIND_TYPE, KIND_UID, KIND_ADDRESS, KIND_ACCEL, KIND_SLOWDOWN, KIND_VMIN,
    KIND_VMAX, KIND_TACHO, KIND_VOLUME, KIND_FUNCTION, KIND_MFX_UID,
    KIND_MFX_TYPE, KIND_MFX_WORD, KIND_SYMBOL, KIND_NAME_CHAR,
    KIND_PROTO_CHAR, KIND_ICON_CHAR, KIND_PIC_SIZE, KIND_ERROR
  } lcp_kind_e;

  typedef struct packed {
    lcp_phase_e  phase;
    logic [15:0] byte_pos;
    logic [7:0]  rec_idx;
    logic [7:0]  bytes_left;
    logic [7:0]  rec_byte;
    logic [31:0] acc;
    logic [5:0]  fn_slot;
    logic [3:0]  fn_group;
    logic        str_ended;
    logic [7:0]  sub_id;
  } lcp_state_t;

  localparam lcp_state_t STATE_CLEAR = '{
    phase: PH_LEN, byte_pos: 16'd0, rec_idx: 8'd0, bytes_left: 8'd0,
    rec_byte: 8'd0, acc: 32'd0, fn_slot: 6'd0, fn_group: 4'd0,
    str_ended: 1'b0, sub_id: 8'd0
  };

  typedef struct packed {
    logic        valid;
    lcp_kind_e   kind;
    logic [4:0]  slot;
    logic [31:0] value;
    logic        done;
  } lcp_res_t;

  typedef struct packed {
    logic      hit;
    lcp_kind_e kind;
  } lcp_rec_kind_t;

  function automatic logic [4:0] type_code(input logic [15:0] word);
    logic [4:0] code;
    code = TYPE_CODE_UNKNOWN;
    for (int i = 0; i < TYPE_WORD_CNT; i++) begin
      if (word == TYPE_WORDS[i]) code = 5'(i);
    end
    return code;
  endfunction

  // Kind of a record that yields one value at its end.
  function automatic lcp_rec_kind_t record_kind(input logic [7:0] idx,
                                                input logic [7:0] len);
    lcp_rec_kind_t rk;
    rk.hit  = 1'b0;
    rk.kind = KIND_TYPE;
    if ((idx >= REC_UID && idx <= REC_VOLUME) || idx == REC_MFX_UID ||
        idx == REC_MFX_TYPE) begin
      rk.hit  = 1'b1;
      rk.kind = lcp_kind_e'(idx[4:0]);
    end else if (idx == REC_SYMBOL_A || idx == REC_SYMBOL_B ||
                 (idx == REC_FUNC_HI && len == SYMBOL_LEN)) begin
      rk.hit  = 1'b1;
      rk.kind = KIND_SYMBOL;
    end
    return rk;
  endfunction

  function automatic logic [31:0] value_mask(input logic [7:0] idx);
    logic [31:0] mask;
    if (idx == REC_UID || idx == REC_MFX_UID) begin
      mask = 32'hFFFF_FFFF;
    end else if (idx == REC_ADDRESS || idx == REC_TACHO) begin
      mask = 32'h0000_FFFF;
    end else begin
      mask = 32'h0000_00FF;
    end
    return mask;
  endfunction

endpackage

[hw/rtl/lcp_step.sv]
// Next-state and result decode for one card byte of the record parser.
module lcp_step (
  input  lcp_pkg::lcp_state_t state_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  input  logic [15:0]         card_size_i,
  output lcp_pkg::lcp_state_t state_o,
  output lcp_pkg::lcp_res_t   res_o
);

  always_comb begin
    lcp_pkg::lcp_state_t    s;
    lcp_pkg::lcp_state_t    n;
    lcp_pkg::lcp_res_t      r;
    lcp_pkg::lcp_rec_kind_t rk;
    logic [7:0]  p;
    logic [7:0]  left_dec;
    logic [7:0]  len;
    logic [31:0] b32;
    logic [31:0] b_hi;
    logic        last;
    logic        fn;
    logic        str_end;

    s        = first_byte_i ? lcp_pkg::STATE_CLEAR : state_i;
    n        = s;
    r        = '0;
    r.kind   = lcp_pkg::KIND_TYPE;
    rk       = '0;
    fn       = 1'b0;
    str_end  = 1'b0;
    p        = s.rec_byte;
    left_dec = s.bytes_left - 8'd1;
    len      = s.rec_byte + s.bytes_left;
    last     = (left_dec == 8'd0);
    b32      = {24'd0, data_byte_i};
    b_hi     = {16'd0, data_byte_i, 8'd0};

    if (s.phase != lcp_pkg::PH_DONE) begin
      if (s.byte_pos >= card_size_i) begin
        n.phase = lcp_pkg::PH_DONE;
      end else begin
        case (s.phase)
          lcp_pkg::PH_LEN: begin
            if (data_byte_i != lcp_pkg::PREAMBLE_LEN) begin
              n.phase = lcp_pkg::PH_DONE;
              r.valid = 1'b1;
              r.kind  = lcp_pkg::KIND_ERROR;
              r.value = b32;
            end else begin
              n.phase = lcp_pkg::PH_ID0;
            end
          end
          lcp_pkg::PH_ID0: begin
            n.acc   = b32;
            n.phase = lcp_pkg::PH_ID1;
          end
          lcp_pkg::PH_ID1: begin
            n.acc   = s.acc | b_hi;
            n.phase = lcp_pkg::PH_IDX;
            r.valid = 1'b1;
            r.kind  = lcp_pkg::KIND_TYPE;
            r.slot  = lcp_pkg::type_code(n.acc[15:0]);
            r.value = n.acc;
          end
          lcp_pkg::PH_IDX: begin
            n.rec_idx = data_byte_i;
            n.phase   = lcp_pkg::PH_RLEN;
          end
          lcp_pkg::PH_RLEN: begin
            n.bytes_left = data_byte_i;
            n.rec_byte   = 8'd0;
            n.acc        = 32'd0;
            n.fn_group   = 4'd0;
            n.fn_slot    = (s.rec_idx == lcp_pkg::REC_FUNC_HI) ? lcp_pkg::FUNC_HI_FIRST
                                                                : 6'd0;
            if (s.rec_idx == lcp_pkg::REC_SECTION0) begin
              n.phase = lcp_pkg::PH_TOT0;
            end else if (data_byte_i == 8'd0) begin
              // An empty value record reports zero right away.
              n.phase = lcp_pkg::PH_IDX;
              rk      = lcp_pkg::record_kind(s.rec_idx, 8'd0);
              r.valid = rk.hit;
              r.kind  = rk.kind;
            end else begin
              n.phase = lcp_pkg::PH_DATA;
            end
          end
          lcp_pkg::PH_DATA: begin
            n.rec_byte   = p + 8'd1;
            n.bytes_left = left_dec;
            n.fn_group   = (s.fn_group == lcp_pkg::GROUP_LAST) ? 4'd0 : s.fn_group + 4'd1;
            if (last) n.phase = lcp_pkg::PH_IDX;
            if (s.rec_idx == lcp_pkg::REC_FUNCTION) begin
              // Each 10-byte group: type, duration, then eight unused bytes.
              if (s.fn_group == 4'd0) begin
                n.acc = b32;
              end else if (s.fn_group == 4'd1) begin
                n.acc = s.acc | b_hi;
              end else if (s.fn_group == lcp_pkg::GROUP_LAST) begin
                fn = 1'b1;
              end
            end else if (s.rec_idx == lcp_pkg::REC_MFX_WORD) begin
              if (!p[0]) begin
                n.acc = b32;
                if (last && p[7:1] < lcp_pkg::MFX_WORDS) begin
                  r.valid = 1'b1;
                  r.kind  = lcp_pkg::KIND_MFX_WORD;
                  r.slot  = 5'(p[7:1]);
                  r.value = b32;
                end
              end else begin
                n.acc = s.acc | b_hi;
                if (p[7:1] < lcp_pkg::MFX_WORDS) begin
                  r.valid = 1'b1;
                  r.kind  = lcp_pkg::KIND_MFX_WORD;
                  r.slot  = 5'(p[7:1]);
                  r.value = n.acc;
                end
              end
            end else if (s.rec_idx == lcp_pkg::REC_FUNC_HI && len == lcp_pkg::FUNC_HI_LEN) begin
              if (!p[0]) begin
                n.acc = b32;
              end else begin
                n.acc = s.acc | b_hi;
                fn    = 1'b1;
              end
            end else begin
              rk = lcp_pkg::record_kind(s.rec_idx, len);
              if (rk.hit) begin
                if (p < 8'd4) n.acc = s.acc | (b32 << {p[1:0], 3'b000});
                if (last) begin
                  r.valid = 1'b1;
                  r.kind  = rk.kind;
                  r.value = n.acc & lcp_pkg::value_mask(s.rec_idx);
                end
              end
            end
          end
          lcp_pkg::PH_TOT0: n.phase = lcp_pkg::PH_TOT1;
          lcp_pkg::PH_TOT1: n.phase = lcp_pkg::PH_SUB_FIRST;
          lcp_pkg::PH_SUB_FIRST, lcp_pkg::PH_SUB_RETRY: begin
            n.sub_id = data_byte_i;
            n.phase  = (data_byte_i == lcp_pkg::SUB_NONE || data_byte_i == lcp_pkg::SUB_END)
                       ? lcp_pkg::PH_DONE : lcp_pkg::PH_SUB_LEN;
          end
          lcp_pkg::PH_SUB_AFTER: begin
            n.sub_id = data_byte_i;
            if (data_byte_i == lcp_pkg::SUB_NONE) begin
              n.phase = lcp_pkg::PH_SUB_RETRY;
            end else if (data_byte_i == lcp_pkg::SUB_END) begin
              n.phase = lcp_pkg::PH_DONE;
            end else begin
              n.phase = lcp_pkg::PH_SUB_LEN;
            end
          end
          lcp_pkg::PH_SUB_LEN: begin
            if (s.sub_id inside {lcp_pkg::SUB_NAME, lcp_pkg::SUB_PROTO, lcp_pkg::SUB_ICON}) begin
              n.bytes_left = data_byte_i;
              n.rec_byte   = 8'd0;
              n.str_ended  = 1'b0;
              n.phase      = (data_byte_i != 8'd0) ? lcp_pkg::PH_STR : lcp_pkg::PH_SUB_AFTER;
            end else if (s.sub_id == lcp_pkg::SUB_PIC) begin
              n.acc   = b32;
              n.phase = lcp_pkg::PH_PIC_HI;
            end else begin
              n.phase = lcp_pkg::PH_SUB_AFTER;
            end
          end
          lcp_pkg::PH_STR: begin
            str_end     = s.str_ended | (data_byte_i == 8'd0);
            n.str_ended = str_end;
            if (!str_end && p < lcp_pkg::STR_SLOTS) begin
              r.valid = 1'b1;
              r.kind  = lcp_pkg::lcp_kind_e'(5'(lcp_pkg::KIND_NAME_CHAR) +
                                             5'(s.sub_id - lcp_pkg::SUB_NAME));
              r.slot  = p[4:0];
              r.value = b32;
            end
            n.rec_byte   = p + 8'd1;
            n.bytes_left = left_dec;
            if (last) n.phase = lcp_pkg::PH_SUB_AFTER;
          end
          lcp_pkg::PH_PIC_HI: begin
            n.acc   = s.acc | b_hi;
            n.phase = lcp_pkg::PH_DONE;
            r.valid = 1'b1;
            r.kind  = lcp_pkg::KIND_PIC_SIZE;
            r.value = n.acc;
          end
          default: n.phase = lcp_pkg::PH_DONE;
        endcase

        // A completed function entry; numbering goes on past the reported range.
        if (fn) begin
          if ({1'b0, s.fn_slot} < 7'(lcp_pkg::FUNCTION_SLOTS)) begin
            r.valid = 1'b1;
            r.kind  = lcp_pkg::KIND_FUNCTION;
            r.slot  = s.fn_slot[4:0];
            r.value = {16'd0, n.acc[15:0]};
          end
          if (s.fn_slot != lcp_pkg::SLOT_MAX) n.fn_slot = s.fn_slot + 6'd1;
        end

        n.byte_pos = (s.byte_pos == lcp_pkg::POS_MAX) ? s.byte_pos : s.byte_pos + 16'd1;
        if (n.phase != lcp_pkg::PH_DONE && n.byte_pos >= card_size_i) begin
          n.phase = lcp_pkg::PH_DONE;
        end
      end
    end

    r.done  = (n.phase == lcp_pkg::PH_DONE);
    state_o = n;
    res_o   = r;
  end

endmodule

[hw/rtl/loco_card_tlv_parser.sv]
// A byte is taken into the input register, then its result into the result register once free.
// One byte per cycle while results are taken; lcp_step computes the next state combinationally.
// Bytes that yield no result still pass through the parser and produce no output transaction.
// Reset clears the parser to wait for the preamble length and sets card_size to 65535.
// A stalled result holds the parser; the input register takes one more byte, then intake stops.
module loco_card_tlv_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_card_size_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  kind_o,
  output logic [4:0]  slot_o,
  output logic [31:0] value_o,
  output logic        done_res_o
);

  logic [15:0]         card_size_q;
  lcp_pkg::lcp_state_t state_q;
  lcp_pkg::lcp_state_t state_d;
  lcp_pkg::lcp_res_t   res_d;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_first_q;
  logic        out_valid_q;
  logic [4:0]  kind_q;
  logic [4:0]  slot_q;
  logic [31:0] value_q;
  logic        done_q;
  logic        step_fire;
  logic        in_fire;

  // A buffered byte is parsed once the result register is free or being emptied.
  assign step_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  lcp_step u_step (
    .state_i      (state_q),
    .data_byte_i  (in_byte_q),
    .first_byte_i (in_first_q),
    .card_size_i  (card_size_q),
    .state_o      (state_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_size_q <= lcp_pkg::CARD_SIZE_RST;
      state_q     <= lcp_pkg::STATE_CLEAR;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) card_size_q <= cfg_card_size_i;
      if (step_fire) state_q <= state_d;
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (step_fire) begin
        in_valid_q <= 1'b0;
      end
      if (step_fire) begin
        out_valid_q <= res_d.valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q  <= data_byte_i;
      in_first_q <= first_byte_i;
    end
    if (step_fire && res_d.valid) begin
      kind_q  <= 5'(res_d.kind);
      slot_q  <= res_d.slot;
      value_q <= res_d.value;
      done_q  <= res_d.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign slot_o      = slot_q;
  assign value_o     = value_q;
  assign done_res_o  = done_q;

endmodule

[hw/rtl/lcp_checker.sv]
// Port-level checks of the card record parser, bound to its top level.
module lcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [15:0] cfg_card_size_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        first_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  kind_o,
  input logic [4:0]  slot_o,
  input logic [31:0] value_o,
  input logic        done_res_o
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(slot_o) &&
                                    $stable(value_o) && $stable(done_res_o))
    else $error("result changed while stalled");

  // A bad preamble and the picture size both end the card.
  a_final_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lcp_pkg::KIND_ERROR || kind_o == lcp_pkg::KIND_PIC_SIZE)
    |-> done_res_o)
    else $error("terminal result without done flag");

  a_type_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == lcp_pkg::KIND_TYPE |-> slot_o <= lcp_pkg::TYPE_CODE_UNKNOWN)
    else $error("card type code out of range");

  // Only type, function, mfx word and string results carry a slot number.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != lcp_pkg::KIND_TYPE && kind_o != lcp_pkg::KIND_FUNCTION &&
    kind_o != lcp_pkg::KIND_MFX_WORD && kind_o != lcp_pkg::KIND_NAME_CHAR &&
    kind_o != lcp_pkg::KIND_PROTO_CHAR && kind_o != lcp_pkg::KIND_ICON_CHAR
    |-> slot_o == 5'd0)
    else $error("slot set on a single-value result");

endmodule

bind loco_card_tlv_parser lcp_checker u_lcp_checker (.*);

[tb/sv/tb_loco_card_tlv_parser.sv]
// Self-checking testbench for the locomotive card TLV parser with a byte-level card predictor.
`timescale 1ns / 1ps

module tb_loco_card_tlv_parser;

  localparam int          QUIET_LIMIT  = 2000;
  localparam int          MAX_REPORTS  = 30;

  typedef enum logic [4:0] {
    TC_0075, TC_00C5, TC_00E5, TC_00E7, TC_00F5, TC_0117, TC_OTHER
  } card_type_e;

  typedef struct packed {
    lcp_pkg::lcp_kind_e kind;
    logic [4:0]         slot;
    logic [31:0]        value;
    logic               done;
  } card_res_t;

  typedef struct packed {
    logic      first;
    logic [7:0] data;
    logic      typed;
    logic      has;
    card_res_t res;
  } card_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_card_size_i = lcp_pkg::CARD_SIZE_RST;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        first_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  kind_o;
  logic [4:0]  slot_o;
  logic [31:0] value_o;
  logic        done_res_o;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  loco_card_tlv_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_card_size_i (cfg_card_size_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .first_byte_i    (first_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .slot_o          (slot_o),
    .value_o         (value_o),
    .done_res_o      (done_res_o)
  );

  // Card parser predictor state.
  lcp_pkg::lcp_phase_e ph;
  logic [15:0] pos;
  logic [15:0] card_limit;
  logic [7:0]  ridx;
  logic [7:0]  left;
  logic [7:0]  rpos;
  logic [31:0] acc;
  logic [5:0]  fslot;
  logic        str_end;
  logic [7:0]  sid;
  bit          hit;
  bit          parsed;
  card_res_t   res;

  card_res_t   expected_q[$];
  logic        stim_first[$];
  logic [7:0]  stim_data[$];

  int mismatches;
  int bytes_sent;
  int parsed_bytes;
  int results_seen;
  int cards_built;
  int quiet_cycles;
  bit in_idle_on = 1'b1;
  bit out_stall_on = 1'b1;

  function automatic void clear_card();
    ph      = lcp_pkg::PH_LEN;
    pos     = 16'd0;
    ridx    = 8'd0;
    left    = 8'd0;
    rpos    = 8'd0;
    acc     = 32'd0;
    fslot   = 6'd0;
    str_end = 1'b0;
    sid     = 8'd0;
  endfunction

  function automatic void emit(input lcp_pkg::lcp_kind_e k, input logic [4:0] s,
                               input logic [31:0] v);
    hit       = 1'b1;
    res.kind  = k;
    res.slot  = s;
    res.value = v;
  endfunction

  function automatic card_type_e type_of(input logic [15:0] word);
    card_type_e c;
    case (word)
      16'h0075: c = TC_0075;
      16'h00C5: c = TC_00C5;
      16'h00E5: c = TC_00E5;
      16'h00E7: c = TC_00E7;
      16'h00F5: c = TC_00F5;
      16'h0117: c = TC_0117;
      default:  c = TC_OTHER;
    endcase
    return c;
  endfunction

  // Records that carry one value, reported once the record is complete.
  function automatic bit value_record(input logic [7:0] idx, input logic [31:0] len,
                                      output lcp_pkg::lcp_kind_e k);
    k = lcp_pkg::KIND_TYPE;
    if ((idx >= lcp_pkg::REC_UID && idx <= lcp_pkg::REC_VOLUME) ||
        idx == lcp_pkg::REC_MFX_UID || idx == lcp_pkg::REC_MFX_TYPE) begin
      k = lcp_pkg::lcp_kind_e'(idx[4:0]);
      return 1'b1;
    end
    if (idx == lcp_pkg::REC_SYMBOL_A || idx == lcp_pkg::REC_SYMBOL_B ||
        (idx == lcp_pkg::REC_FUNC_HI && len == 32'(lcp_pkg::SYMBOL_LEN))) begin
      k = lcp_pkg::KIND_SYMBOL;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] width_mask(input logic [7:0] idx);
    if (idx == lcp_pkg::REC_UID || idx == lcp_pkg::REC_MFX_UID) return 32'hFFFF_FFFF;
    if (idx == lcp_pkg::REC_ADDRESS || idx == lcp_pkg::REC_TACHO) return 32'h0000_FFFF;
    return 32'h0000_00FF;
  endfunction

  function automatic void function_entry();
    if (fslot < lcp_pkg::FUNCTION_SLOTS)
      emit(lcp_pkg::KIND_FUNCTION, fslot[4:0], {16'd0, acc[15:0]});
    if (fslot < lcp_pkg::SLOT_MAX) fslot++;
  endfunction

  function automatic void open_record(input logic [7:0] len);
    lcp_pkg::lcp_kind_e k;
    left  = len;
    rpos  = 8'd0;
    acc   = 32'd0;
    fslot = (ridx == lcp_pkg::REC_FUNC_HI) ? lcp_pkg::FUNC_HI_FIRST : 6'd0;
    if (ridx == lcp_pkg::REC_SECTION0) begin
      ph = lcp_pkg::PH_TOT0;
    end else if (len == 8'd0) begin
      ph = lcp_pkg::PH_IDX;
      if (value_record(ridx, 32'd0, k)) emit(k, 5'd0, 32'd0);
    end else begin
      ph = lcp_pkg::PH_DATA;
    end
  endfunction

  function automatic void record_byte(input logic [7:0] b);
    logic [7:0]  p;
    logic [31:0] len;
    logic [6:0]  w;
    int unsigned grp;
    bit          last;
    lcp_pkg::lcp_kind_e k;
    p    = rpos;
    rpos++;
    left--;
    last = (left == 8'd0);
    len  = 32'(p) + 32'd1 + 32'(left);
    w    = 7'(p >> 1);
    if (last) ph = lcp_pkg::PH_IDX;
    if (ridx == lcp_pkg::REC_FUNCTION) begin
      // Only the first two bytes of each group matter; the entry is out at its last byte.
      grp = p % lcp_pkg::FUNC_GROUP_LEN;
      if (grp == 0) acc = 32'(b);
      else if (grp == 1) acc = acc | (32'(b) << 8);
      else if (grp == lcp_pkg::FUNC_GROUP_LEN - 1) function_entry();
    end else if (ridx == lcp_pkg::REC_MFX_WORD) begin
      if (!p[0]) begin
        acc = 32'(b);
        if (last && w < lcp_pkg::MFX_WORDS) emit(lcp_pkg::KIND_MFX_WORD, w[4:0], acc);
      end else begin
        acc = acc | (32'(b) << 8);
        if (w < lcp_pkg::MFX_WORDS) emit(lcp_pkg::KIND_MFX_WORD, w[4:0], acc);
      end
    end else if (ridx == lcp_pkg::REC_FUNC_HI && len == 32'(lcp_pkg::FUNC_HI_LEN)) begin
      if (!p[0]) begin
        acc = 32'(b);
      end else begin
        acc = acc | (32'(b) << 8);
        function_entry();
      end
    end else if (value_record(ridx, len, k)) begin
      if (p < 8'd4) acc = acc | (32'(b) << (8 * p));
      if (last) emit(k, 5'd0, acc & width_mask(ridx));
    end
  endfunction

  function automatic void sub_len(input logic [7:0] b);
    if (sid == lcp_pkg::SUB_NAME || sid == lcp_pkg::SUB_PROTO || sid == lcp_pkg::SUB_ICON) begin
      left    = b;
      rpos    = 8'd0;
      str_end = 1'b0;
      ph      = (b != 8'd0) ? lcp_pkg::PH_STR : lcp_pkg::PH_SUB_AFTER;
    end else if (sid == lcp_pkg::SUB_PIC) begin
      acc = 32'(b);
      ph  = lcp_pkg::PH_PIC_HI;
    end else begin
      ph = lcp_pkg::PH_SUB_AFTER;
    end
  endfunction

  function automatic void string_char(input logic [7:0] b);
    logic [4:0] kc;
    kc = 5'(lcp_pkg::KIND_NAME_CHAR) + 5'(sid - lcp_pkg::SUB_NAME);
    if (b == 8'd0) str_end = 1'b1;
    if (!str_end && rpos < lcp_pkg::STR_SLOTS)
      emit(lcp_pkg::lcp_kind_e'(kc), rpos[4:0], 32'(b));
    rpos++;
    left--;
    if (left == 8'd0) ph = lcp_pkg::PH_SUB_AFTER;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    case (ph)
      lcp_pkg::PH_LEN: begin
        if (b != lcp_pkg::PREAMBLE_LEN) begin
          ph = lcp_pkg::PH_DONE;
          emit(lcp_pkg::KIND_ERROR, 5'd0, 32'(b));
        end else begin
          ph = lcp_pkg::PH_ID0;
        end
      end
      lcp_pkg::PH_ID0: begin
        acc = 32'(b);
        ph  = lcp_pkg::PH_ID1;
      end
      lcp_pkg::PH_ID1: begin
        acc = acc | (32'(b) << 8);
        ph  = lcp_pkg::PH_IDX;
        emit(lcp_pkg::KIND_TYPE, 5'(type_of(acc[15:0])), acc);
      end
      lcp_pkg::PH_IDX: begin
        ridx = b;
        ph   = lcp_pkg::PH_RLEN;
      end
      lcp_pkg::PH_RLEN:  open_record(b);
      lcp_pkg::PH_DATA:  record_byte(b);
      lcp_pkg::PH_TOT0:  ph = lcp_pkg::PH_TOT1;
      lcp_pkg::PH_TOT1:  ph = lcp_pkg::PH_SUB_FIRST;
      lcp_pkg::PH_SUB_FIRST, lcp_pkg::PH_SUB_RETRY: begin
        sid = b;
        ph  = (b == lcp_pkg::SUB_NONE || b == lcp_pkg::SUB_END) ? lcp_pkg::PH_DONE
                                                                : lcp_pkg::PH_SUB_LEN;
      end
      lcp_pkg::PH_SUB_AFTER: begin
        // A zero id right after a sub-record is skipped once.
        sid = b;
        if (b == lcp_pkg::SUB_NONE) ph = lcp_pkg::PH_SUB_RETRY;
        else if (b == lcp_pkg::SUB_END) ph = lcp_pkg::PH_DONE;
        else ph = lcp_pkg::PH_SUB_LEN;
      end
      lcp_pkg::PH_SUB_LEN: sub_len(b);
      lcp_pkg::PH_STR:     string_char(b);
      lcp_pkg::PH_PIC_HI: begin
        acc = acc | (32'(b) << 8);
        ph  = lcp_pkg::PH_DONE;
        emit(lcp_pkg::KIND_PIC_SIZE, 5'd0, acc);
      end
      default: ph = lcp_pkg::PH_DONE;
    endcase
  endfunction

  function automatic bit card_step(input logic first, input logic [7:0] b, output card_res_t r);
    hit    = 1'b0;
    parsed = 1'b0;
    res    = '0;
    r      = '0;
    if (first) clear_card();
    if (ph == lcp_pkg::PH_DONE) return 1'b0;
    if (pos >= card_limit) begin
      ph = lcp_pkg::PH_DONE;
      return 1'b0;
    end
    parsed = 1'b1;
    parse_byte(b);
    if (pos != lcp_pkg::POS_MAX) pos++;
    if (ph != lcp_pkg::PH_DONE && pos >= card_limit) ph = lcp_pkg::PH_DONE;
    r      = res;
    r.done = (ph == lcp_pkg::PH_DONE);
    return hit;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Drives one byte, waits for its transaction and records what the card should yield.
  task automatic push_byte(input logic first, input logic [7:0] data, input bit typed,
                           input bit t_has, input card_res_t t_res);
    int        gap;
    bit        got;
    card_res_t r;
    @(negedge clk_i);
    gap = (in_idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= data;
    first_byte_i <= first;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    got = card_step(first, data, r);
    if (typed) begin
      got = t_has;
      r   = t_res;
    end
    if (got) expected_q.push_back(r);
    bytes_sent++;
    if (parsed) parsed_bytes++;
  endtask

  task automatic set_card_size(input logic [15:0] new_size);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    // Bytes without a result may still sit in the pipeline.
    repeat (4) @(negedge clk_i);
    cfg_card_size_i <= new_size;
    cfg_we_i        <= 1'b1;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    card_limit = new_size;
  endtask

  function automatic void add_byte(input logic first, input logic [7:0] data);
    stim_first.push_back(first);
    stim_data.push_back(data);
  endfunction

  function automatic void add_body(input int n, input int edge_pct);
    repeat (n) begin
      if (int'($urandom_range(0, 99)) < edge_pct)
        add_byte(1'b0, $urandom_range(0, 1) ? 8'hFF : 8'h00);
      else add_byte(1'b0, 8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_text(input int n);
    repeat (n) add_byte(1'b0, ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
  endfunction

  function automatic void make_card();
    int          n_rec;
    int          pick;
    int          len;
    logic [7:0]  idx;
    logic [15:0] word;
    cards_built++;
    if ($urandom_range(0, 9) == 0) add_byte(1'b1, 8'($urandom_range(0, 255)));
    else add_byte(1'b1, lcp_pkg::PREAMBLE_LEN);
    if ($urandom_range(0, 3) == 0) word = 16'($urandom_range(0, 65535));
    else word = lcp_pkg::TYPE_WORDS[$urandom_range(0, lcp_pkg::TYPE_WORD_CNT - 1)];
    add_byte(1'b0, word[7:0]);
    add_byte(1'b0, word[15:8]);
    n_rec = $urandom_range(0, 6);
    repeat (n_rec) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) idx = 8'(pick + 1);
      else if (pick < 17) idx = lcp_pkg::REC_FUNCTION;
      else idx = 8'($urandom_range(16, 255));
      if (idx == lcp_pkg::REC_FUNCTION) begin
        if ($urandom_range(0, 29) == 0) len = 255;
        else len = 10 * int'($urandom_range(0, 4)) +
                   (($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 9)) : 0);
      end else if (idx == lcp_pkg::REC_FUNC_HI) begin
        pick = $urandom_range(0, 2);
        len  = (pick == 0) ? 32 : (pick == 1) ? 1 : int'($urandom_range(0, 6));
      end else if (idx == lcp_pkg::REC_MFX_WORD) begin
        len = $urandom_range(0, 20);
      end else begin
        len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12))
                                          : int'($urandom_range(0, 5));
      end
      add_byte(1'b0, idx);
      add_byte(1'b0, 8'(len));
      add_body(len, 15);
    end
    if ($urandom_range(0, 9) < 7) begin
      add_byte(1'b0, lcp_pkg::REC_SECTION0);
      add_body(3, 10);
      repeat ($urandom_range(0, 4)) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          len = ($urandom_range(0, 5) == 0) ? int'($urandom_range(30, 48))
                                            : int'($urandom_range(0, 10));
          add_byte(1'b0, lcp_pkg::SUB_NAME + 8'($urandom_range(0, 2)));
          add_byte(1'b0, 8'(len));
          add_text(len);
        end else if (pick < 9) begin
          add_byte(1'b0, 8'($urandom_range(1, 254)));
          add_byte(1'b0, 8'($urandom_range(0, 255)));
        end else begin
          add_byte(1'b0, lcp_pkg::SUB_NONE);
        end
      end
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        add_byte(1'b0, lcp_pkg::SUB_PIC);
        add_body(2, 30);
      end else if (pick == 1) begin
        add_byte(1'b0, lcp_pkg::SUB_END);
      end else if (pick == 2) begin
        add_byte(1'b0, lcp_pkg::SUB_NONE);
        add_byte(1'b0, lcp_pkg::SUB_NONE);
      end
    end
    // Trailing noise, now and then with a restart in the middle.
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 5))
        add_byte($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_stim();
    while (stim_data.size() != 0) push_byte(stim_first.pop_front(), stim_data.pop_front(),
                                            1'b0, 1'b0, '0);
  endtask

  function automatic card_row_t pl(input logic first, input logic [7:0] data);
    return '{first: first, data: data, typed: 1'b0, has: 1'b0, res: '0};
  endfunction

  function automatic card_row_t tl(input logic first, input logic [7:0] data, input logic has,
                                   input lcp_pkg::lcp_kind_e k, input logic [4:0] s,
                                   input logic [31:0] v, input logic d);
    return '{first: first, data: data, typed: 1'b1, has: has,
             res: '{kind: k, slot: s, value: v, done: d}};
  endfunction

  // Result receiver with random back-pressure.
  initial begin
    int hold;
    hold        = 0;
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold > 0) hold--;
      else if (out_stall_on && $urandom_range(0, 5) == 0) hold = idle_len();
      out_ready_i <= (hold == 0);
    end
  end

  always @(posedge clk_i) begin
    card_res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d slot %0d value %h done %b",
                                  kind_o, slot_o, value_o, done_res_o));
      end else begin
        want = expected_q.pop_front();
        if (kind_o !== want.kind || slot_o !== want.slot || value_o !== want.value ||
            done_res_o !== want.done)
          report_mismatch($sformatf("got kind %0d slot %0d value %h done %b, want %0d %0d %h %b",
                                    kind_o, slot_o, value_o, done_res_o,
                                    want.kind, want.slot, want.value, want.done));
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results still due",
               QUIET_LIMIT, expected_q.size());
      $display("** loco_card_tlv_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    card_row_t   dir_rows [26];
    logic [15:0] size_plan [5];
    int          quota [5];
    int          phase_start;
    size_plan = '{16'd3, 16'($urandom_range(6, 40)), lcp_pkg::CARD_SIZE_RST,
                  16'($urandom_range(41, 400)), 16'($urandom_range(401, 3000))};
    quota     = '{80, 260, 400, 260, 150};
    card_limit = lcp_pkg::CARD_SIZE_RST;
    clear_card();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Bad preamble, bytes after the end, a known type word, a zero-length record,
    // a short uid, a symbol, a name string with its end and the largest picture size.
    dir_rows = '{
      tl(1'b1, 8'h05, 1'b1, lcp_pkg::KIND_ERROR, 5'd0, 32'h05, 1'b1),
      tl(1'b0, 8'hFF, 1'b0, lcp_pkg::KIND_TYPE, 5'd0, 32'd0, 1'b0),
      tl(1'b1, lcp_pkg::PREAMBLE_LEN, 1'b0, lcp_pkg::KIND_TYPE, 5'd0, 32'd0, 1'b0),
      pl(1'b0, 8'h17),
      tl(1'b0, 8'h01, 1'b1, lcp_pkg::KIND_TYPE, 5'(TC_0117), 32'h0117, 1'b0),
      pl(1'b0, lcp_pkg::REC_ADDRESS),
      tl(1'b0, 8'h00, 1'b1, lcp_pkg::KIND_ADDRESS, 5'd0, 32'd0, 1'b0),
      pl(1'b0, lcp_pkg::REC_UID),
      pl(1'b0, 8'h03),
      pl(1'b0, 8'hFF),
      pl(1'b0, 8'hFF),
      pl(1'b0, 8'hFF),
      pl(1'b0, lcp_pkg::REC_FUNC_HI),
      pl(1'b0, lcp_pkg::SYMBOL_LEN),
      pl(1'b0, 8'h7F),
      pl(1'b0, lcp_pkg::REC_SECTION0),
      pl(1'b0, 8'h00),
      pl(1'b0, 8'h34),
      pl(1'b0, 8'h12),
      pl(1'b0, lcp_pkg::SUB_NAME),
      pl(1'b0, 8'h02),
      pl(1'b0, 8'h41),
      pl(1'b0, 8'h00),
      pl(1'b0, lcp_pkg::SUB_PIC),
      pl(1'b0, 8'hFF),
      tl(1'b0, 8'hFF, 1'b1, lcp_pkg::KIND_PIC_SIZE, 5'd0, 32'h0000_FFFF, 1'b1)
    };
    cards_built = 2;
    foreach (dir_rows[i])
      push_byte(dir_rows[i].first, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].has,
                dir_rows[i].res);

    for (int step_i = 0; step_i < 5; step_i++) begin
      set_card_size(size_plan[step_i]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < quota[step_i]) begin
        in_idle_on   = ($urandom_range(0, 3) != 0);
        out_stall_on = ($urandom_range(0, 3) != 0);
        make_card();
        send_stim();
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d card bytes in %0d cards, %0d of them parsed; checked %0d results.",
             bytes_sent, cards_built, parsed_bytes, results_seen);
    $display("Card sizes ran from 3 up to 65535, with cards cut off in the middle of records.");
    if (mismatches == 0) begin
      $display("** loco_card_tlv_parser: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** loco_card_tlv_parser: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lcp_pkg.sv
hw/rtl/lcp_step.sv
hw/rtl/loco_card_tlv_parser.sv
hw/rtl/lcp_checker.sv
tb/sv/tb_loco_card_tlv_parser.sv
